// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files of the packet timestamper.
// Each macro places one labelled concurrent assertion, clocked on the rising
// edge and switched off while reset is held low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/opt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opt_pkg
// Types, constants and helper functions of the Opus packet timestamper:
// field widths, status codes, TOC decoding and the divide-by-three digit step.
// ----------------------------------------------------------------------------
package opt_pkg;

    // Field widths of the channels and of the running state.
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int DUR_W    = 18;
    localparam int TS_W     = 63;
    localparam int TOTAL_W  = 64;
    localparam int SKIP_W   = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 5;
    localparam int CODE_W   = 2;
    localparam int COUNT_W  = 6;
    localparam int FSIZE_W  = 12;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NO_COUNT = 2'd2
    } status_t;

    // Frame count codes of the TOC byte.
    localparam logic [CODE_W-1:0] CODE_ONE       = 2'd0;
    localparam logic [CODE_W-1:0] CODE_TWO_EQUAL = 2'd1;
    localparam logic [CODE_W-1:0] CODE_TWO_VAR   = 2'd2;
    localparam logic [CODE_W-1:0] CODE_ARBITRARY = 2'd3;

    // A code-3 packet needs its count byte, so at least this many bytes.
    localparam logic [LEN_W-1:0] MIN_LEN_COUNT = 16'd2;

    // Nanoseconds per three samples at 48 kHz, and its thirds.
    localparam int unsigned NS_PER_THREE = 62500;
    localparam int FRAC_W = 16;
    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(NS_PER_THREE / 3);
    localparam logic [FRAC_W-1:0] FRAC_TWO = FRAC_W'((2 * NS_PER_THREE) / 3);

    // Largest timestamp, and the largest sample distance that scales below it.
    localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};
    localparam logic [TOTAL_W-1:0] SAT_LIMIT =
        TOTAL_W'(((67'd3 << 63) - 67'd1) / 67'(NS_PER_THREE));

    // Radix-4 division by three: the dividend width covers SAT_LIMIT.
    localparam int DIV_W            = 50;
    localparam int DIV_DIGITS       = DIV_W / 2;
    localparam int DIGITS_PER_STAGE = 5;
    localparam int DIV_STAGES       = DIV_DIGITS / DIGITS_PER_STAGE;

    // Quotient split for the two partial products.
    localparam int Q_SPLIT = 24;
    localparam int LO_W    = 40;
    localparam int HI_W    = 42;
    localparam int SUM_W   = HI_W + Q_SPLIT;

    // Depth of the queue between front and back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // One classified item as it travels from front to back.
    typedef struct packed {
        logic [DUR_W-1:0] dur;
        status_t          status;
    } opt_item_t;

    // One radix-4 digit step of the division by three.
    typedef struct packed {
        logic [1:0] quo;
        logic [1:0] rem;
    } div3_t;

    // Frame length in 48 kHz samples for a TOC configuration number.
    function automatic logic [FSIZE_W-1:0] toc_frame_len(input logic [CFG_W-1:0] cfg);
        logic [FSIZE_W-1:0] size;
        case (cfg) inside
            [5'd0:5'd11]:
            begin
                case (cfg[1:0])
                    2'd0:    size = 12'd480;
                    2'd1:    size = 12'd960;
                    2'd2:    size = 12'd1920;
                    default: size = 12'd2880;
                endcase
            end
            [5'd12:5'd15]:
            begin
                size = cfg[0] ? 12'd960 : 12'd480;
            end
            default:
            begin
                case (cfg[1:0])
                    2'd0:    size = 12'd120;
                    2'd1:    size = 12'd240;
                    2'd2:    size = 12'd480;
                    default: size = 12'd960;
                endcase
            end
        endcase
        return size;
    endfunction

    // Partial remainder times four plus the next digit, divided by three.
    function automatic div3_t div3_step(input logic [3:0] cur);
        div3_t res;
        case (cur) inside
            [4'd0:4'd2]:
            begin
                res.quo = 2'd0;
                res.rem = cur[1:0];
            end
            [4'd3:4'd5]:
            begin
                res.quo = 2'd1;
                res.rem = 2'(cur - 4'd3);
            end
            [4'd6:4'd8]:
            begin
                res.quo = 2'd2;
                res.rem = 2'(cur - 4'd6);
            end
            [4'd9:4'd11]:
            begin
                res.quo = 2'd3;
                res.rem = 2'(cur - 4'd9);
            end
            default:
            begin
                res.quo = 2'd0;
                res.rem = 2'd0;
            end
        endcase
        return res;
    endfunction

endpackage

// File: rtl/opt_packet_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opt_packet_if
// Valid/ready channel that carries the leading bytes and length of a packet.
// ----------------------------------------------------------------------------
interface opt_packet_if
    import opt_pkg::*;
();

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] toc_byte;
    logic [BYTE_W-1:0] count_byte;
    logic [LEN_W-1:0]  packet_length;

    modport source (output valid, output toc_byte, output count_byte,
                    output packet_length, input ready);
    modport sink   (input valid, input toc_byte, input count_byte,
                    input packet_length, output ready);

endinterface

// File: rtl/opt_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opt_result_if
// Valid/ready channel that carries the duration, timestamp and status.
// ----------------------------------------------------------------------------
interface opt_result_if
    import opt_pkg::*;
();

    logic                valid;
    logic                ready;
    logic [DUR_W-1:0]    duration_samples;
    logic [TS_W-1:0]     timestamp_ns;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output duration_samples, output timestamp_ns,
                    output status, input ready);
    modport sink   (input valid, input duration_samples, input timestamp_ns,
                    input status, output ready);

endinterface

// File: rtl/opt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opt_front
// Accepts packet items, decodes the TOC byte into a duration and checks that
// the needed bytes are present, then registers the classified item.
// ----------------------------------------------------------------------------
module opt_front
    import opt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    opt_packet_if.sink    packet,
    output logic          item_valid,
    output opt_item_t     item,
    input  logic          item_ready
);

    logic                valid_reg;
    opt_item_t           item_reg;
    opt_item_t           item_next;
    logic [CODE_W-1:0]   code;
    logic [COUNT_W-1:0]  frames;
    logic                accept;

    // The output register is free when empty or when its item moves on.
    assign packet.ready = !valid_reg || item_ready;
    assign accept       = packet.valid && packet.ready;

    // Frame count from the count code.
    always_comb
    begin
        code = packet.toc_byte[1:0];
        case (code)
            CODE_ONE:       frames = 6'd1;
            CODE_TWO_EQUAL: frames = 6'd2;
            CODE_TWO_VAR:   frames = 6'd2;
            CODE_ARBITRARY: frames = packet.count_byte[COUNT_W-1:0];
            default:        frames = 6'd2;
        endcase
    end

    // Classification: an empty packet, a code-3 packet without its count
    // byte, or a good packet with its duration.
    always_comb
    begin
        item_next.dur    = DUR_W'(toc_frame_len(packet.toc_byte[7:3])) * DUR_W'(frames);
        item_next.status = ST_OK;
        if (packet.packet_length == '0)
        begin
            item_next.dur    = '0;
            item_next.status = ST_EMPTY;
        end
        else if (code == CODE_ARBITRARY && packet.packet_length < MIN_LEN_COUNT)
        begin
            item_next.dur    = '0;
            item_next.status = ST_NO_COUNT;
        end
    end

    // Occupancy of the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (packet.ready)
        begin
            valid_reg <= packet.valid;
        end
    end

    // Item payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/opt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opt_fifo
// Short queue of classified items between the front and the back, so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module opt_fifo
    import opt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  opt_item_t  in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output opt_item_t  out_item
);

    opt_item_t            entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;
    logic                 push;
    logic                 pop;

    assign in_ready  = (count_reg != (FIFO_AW + 1)'(FIFO_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = entry_reg[rd_ptr_reg];

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: rtl/opt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opt_back
// Accumulates the sample total, subtracts the pre-skip, scales the distance
// to nanoseconds through a pipelined division by three and a split multiply,
// applies the monotonic clamp and holds the result in an output register.
// ----------------------------------------------------------------------------
module opt_back
    import opt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SKIP_W-1:0]   skip_len,
    input  logic                item_valid,
    output logic                item_ready,
    input  opt_item_t           item,
    opt_result_if.source        result
);

    logic                adv;

    // Running state.
    logic [TOTAL_W-1:0]  total_reg;
    logic [TS_W-1:0]     prev_reg;
    logic [TOTAL_W-1:0]  total_sum;

    // Accumulate stage.
    logic                a_valid_reg;
    opt_item_t           a_item_reg;
    logic [TOTAL_W-1:0]  a_total_reg;

    // Pre-skip stage.
    logic                b_valid_reg;
    opt_item_t           b_item_reg;
    logic                b_pos_reg;
    logic [TOTAL_W-1:0]  b_diff_reg;

    // Division stages; index 0 loads the dividend and checks saturation.
    logic                div_valid_reg [DIV_STAGES+1];
    opt_item_t           div_item_reg  [DIV_STAGES+1];
    logic                div_zero_reg  [DIV_STAGES+1];
    logic                div_sat_reg   [DIV_STAGES+1];
    logic [DIV_W-1:0]    div_work_reg  [DIV_STAGES+1];
    logic [1:0]          div_rem_reg   [DIV_STAGES+1];
    logic [DIV_W-1:0]    div_work_next [DIV_STAGES+1];
    logic [1:0]          div_rem_next  [DIV_STAGES+1];

    // Partial product stage.
    logic                m_valid_reg;
    opt_item_t           m_item_reg;
    logic                m_zero_reg;
    logic                m_sat_reg;
    logic [LO_W-1:0]     m_lo_reg;
    logic [HI_W-1:0]     m_hi_reg;
    logic [FRAC_W-1:0]   frac;

    // Sum stage.
    logic                n_valid_reg;
    opt_item_t           n_item_reg;
    logic [TS_W-1:0]     n_ts_reg;
    logic [SUM_W-1:0]    sum;

    // Output register.
    logic                out_valid_reg;
    logic [DUR_W-1:0]    out_dur_reg;
    logic [TS_W-1:0]     out_ts_reg;
    status_t             out_status_reg;
    logic [TS_W-1:0]     ts_clamped;

    // The whole pipeline moves when the output register can take an item.
    assign adv        = !out_valid_reg || result.ready;
    assign item_ready = adv;
    assign total_sum  = total_reg + TOTAL_W'(item.dur);

    // Division by three, a few radix-4 digits per stage, most significant
    // digit first; quotient digits shift in at the bottom.
    always_comb
    begin
        logic [DIV_W-1:0] w;
        logic [1:0]       r;
        div3_t            st;
        div_work_next[0] = b_diff_reg[DIV_W-1:0];
        div_rem_next[0]  = 2'd0;
        for (int s = 1; s <= DIV_STAGES; s++)
        begin
            w = div_work_reg[s-1];
            r = div_rem_reg[s-1];
            for (int k = 0; k < DIGITS_PER_STAGE; k++)
            begin
                st = div3_step({r, w[DIV_W-1 -: 2]});
                w  = {w[DIV_W-3:0], st.quo};
                r  = st.rem;
            end
            div_work_next[s] = w;
            div_rem_next[s]  = r;
        end
    end

    // Share of the remainder in nanoseconds.
    always_comb
    begin
        case (div_rem_reg[DIV_STAGES])
            2'd1:    frac = FRAC_ONE;
            2'd2:    frac = FRAC_TWO;
            default: frac = '0;
        endcase
    end

    // Recombine the partial products.
    assign sum = {m_hi_reg, {Q_SPLIT{1'b0}}} + SUM_W'(m_lo_reg);

    // Never below the previous timestamp.
    assign ts_clamped = (n_ts_reg < prev_reg) ? prev_reg : n_ts_reg;

    // Control state: stage occupancy, sample total and last timestamp.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            for (int s = 0; s <= DIV_STAGES; s++)
            begin
                div_valid_reg[s] <= 1'b0;
            end
            m_valid_reg   <= 1'b0;
            n_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            prev_reg      <= '0;
        end
        else if (adv)
        begin
            a_valid_reg      <= item_valid;
            b_valid_reg      <= a_valid_reg;
            div_valid_reg[0] <= b_valid_reg;
            for (int s = 1; s <= DIV_STAGES; s++)
            begin
                div_valid_reg[s] <= div_valid_reg[s-1];
            end
            m_valid_reg   <= div_valid_reg[DIV_STAGES];
            n_valid_reg   <= m_valid_reg;
            out_valid_reg <= n_valid_reg;
            if (item_valid && item.status == ST_OK)
            begin
                total_reg <= total_sum;
            end
            if (n_valid_reg && n_item_reg.status == ST_OK)
            begin
                prev_reg <= ts_clamped;
            end
        end
    end

    // Payload of every stage.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Accumulate.
            a_item_reg  <= item;
            a_total_reg <= total_sum;

            // Distance above the pre-skip.
            b_item_reg <= a_item_reg;
            b_pos_reg  <= a_total_reg > TOTAL_W'(skip_len);
            b_diff_reg <= a_total_reg - TOTAL_W'(skip_len);

            // Dividend load, saturation check and digit stages.
            div_item_reg[0] <= b_item_reg;
            div_zero_reg[0] <= !b_pos_reg;
            div_sat_reg[0]  <= b_diff_reg > SAT_LIMIT;
            for (int s = 1; s <= DIV_STAGES; s++)
            begin
                div_item_reg[s] <= div_item_reg[s-1];
                div_zero_reg[s] <= div_zero_reg[s-1];
                div_sat_reg[s]  <= div_sat_reg[s-1];
            end
            for (int s = 0; s <= DIV_STAGES; s++)
            begin
                div_work_reg[s] <= div_work_next[s];
                div_rem_reg[s]  <= div_rem_next[s];
            end

            // Quotient times 62500 in two halves, remainder share folded in.
            m_item_reg <= div_item_reg[DIV_STAGES];
            m_zero_reg <= div_zero_reg[DIV_STAGES];
            m_sat_reg  <= div_sat_reg[DIV_STAGES];
            m_lo_reg   <= LO_W'(div_work_reg[DIV_STAGES][Q_SPLIT-1:0])
                          * LO_W'(NS_PER_THREE) + LO_W'(frac);
            m_hi_reg   <= HI_W'(div_work_reg[DIV_STAGES][DIV_W-1:Q_SPLIT])
                          * HI_W'(NS_PER_THREE);

            // Scaled timestamp with zero floor and saturation.
            n_item_reg <= m_item_reg;
            if (m_zero_reg)
            begin
                n_ts_reg <= '0;
            end
            else if (m_sat_reg)
            begin
                n_ts_reg <= TS_MAX;
            end
            else
            begin
                n_ts_reg <= sum[TS_W-1:0];
            end

            // Result; errors carry zero fields.
            out_dur_reg    <= n_item_reg.dur;
            out_status_reg <= n_item_reg.status;
            out_ts_reg     <= (n_item_reg.status == ST_OK) ? ts_clamped : '0;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.duration_samples = out_dur_reg;
    assign result.timestamp_ns     = out_ts_reg;
    assign result.status           = out_status_reg;

endmodule

// File: rtl/opus_packet_timestamper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opus_packet_timestamper_top
// Opus packet timestamper: decodes the TOC byte of each packet into a
// duration, keeps the running sample total and gives a monotonic nanosecond
// presentation time after the decoder pre-skip.
//
//   Channel   Role     Item
//   packet    sink     toc_byte, count_byte, packet_length
//   result    source   duration_samples, timestamp_ns, status
//   cfg       write    decoder pre-skip in samples (cfg_we, cfg_wdata)
//
// One item is taken per cycle unless the queue is full; each result passes the
// front register, the queue and the back stages. The sample total loop is a
// 64-bit adder; scaling takes five division stages and a split 62500 multiply.
// Reset clears the total, the last timestamp and the pre-skip; no clearing
// pass follows. A stalled result freezes the back pipeline while the front
// keeps taking items until the four-entry queue is full.
// ----------------------------------------------------------------------------
module opus_packet_timestamper_top
    import opt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [SKIP_W-1:0]  cfg_wdata,
    opt_packet_if.sink         packet,
    opt_result_if.source       result
);

    logic [SKIP_W-1:0] skip_len_reg;
    logic              f_valid;
    logic              f_ready;
    opt_item_t         f_item;
    logic              q_valid;
    logic              q_ready;
    opt_item_t         q_item;

    // Pre-skip register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_len_reg <= '0;
        end
        else if (cfg_we)
        begin
            skip_len_reg <= cfg_wdata;
        end
    end

    // Front: accept and classify.
    opt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .packet     (packet),
        .item_valid (f_valid),
        .item       (f_item),
        .item_ready (f_ready)
    );

    // Queue between front and back.
    opt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // Back: accumulate, scale and clamp.
    opt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .skip_len   (skip_len_reg),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .result     (result)
    );

endmodule

// File: rtl/opt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opt_checker
// Port-level checks of the timestamper: error results carry zero fields,
// good timestamps never fall, a stalled result holds, and no result appears
// without an accepted item behind it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module opt_checker
    import opt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [DUR_W-1:0]    out_dur,
    input  logic [TS_W-1:0]     out_ts,
    input  logic [STATUS_W-1:0] out_status
);

    localparam int OUTST_W = 6;

    logic [OUTST_W-1:0] outstanding_reg;
    logic [TS_W-1:0]    last_ts_reg;
    logic               in_acc;
    logic               out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Items accepted but not yet delivered, and the last good timestamp.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
            last_ts_reg     <= '0;
        end
        else
        begin
            if (in_acc && !out_acc)
            begin
                outstanding_reg <= outstanding_reg + 1'b1;
            end
            else if (out_acc && !in_acc)
            begin
                outstanding_reg <= outstanding_reg - 1'b1;
            end
            if (out_acc && out_status == ST_OK)
            begin
                last_ts_reg <= out_ts;
            end
        end
    end

    `ASSERT_IMPLIES(a_error_zero, clk, rst_n, out_valid && out_status != ST_OK,
        out_dur == '0 && out_ts == '0, "error result with non-zero fields")

    `ASSERT_IMPLIES(a_monotonic, clk, rst_n, out_valid && out_status == ST_OK,
        out_ts >= last_ts_reg, "timestamp fell below the previous one")

    `ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_dur) && $stable(out_ts) && $stable(out_status),
        "stalled result changed")

    `ASSERT_IMPLIES(a_no_phantom, clk, rst_n, out_valid,
        outstanding_reg != '0, "result without an accepted item")

endmodule

bind opus_packet_timestamper_top opt_checker u_opt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (packet.valid),
    .in_ready   (packet.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_dur    (result.duration_samples),
    .out_ts     (result.timestamp_ns),
    .out_status (result.status)
);

// File: tb/opt_timestamp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opt_timestamp_checker
// Watches the packet, result and configuration ports of the packet
// timestamper. It keeps its own sample total, last timestamp and pre-skip,
// works out the result of every accepted packet and compares each accepted
// result, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module opt_timestamp_checker
    import opt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SKIP_W-1:0] cfg_wdata,
    opt_packet_if             packet,
    opt_result_if             result,
    output int                fail_count,
    output int                outstanding,
    output int                checked_count,
    output int                empty_count,
    output int                missing_count,
    output int                clamp_count
);

    // One predicted result.
    typedef struct {
        logic [DUR_W-1:0] dur;
        logic [TS_W-1:0]  ts;
        status_t          status;
    } stamp_t;

    // Predicted timing state and running tallies.
    logic [TOTAL_W-1:0] sample_sum;
    logic [TS_W-1:0]    last_stamp;
    logic [SKIP_W-1:0]  skip_len;
    stamp_t             pending_stamps[$];
    int                 fails;
    int                 checked;
    int                 empties;
    int                 missing;
    int                 clamps;

    // Samples per frame for a TOC configuration number.
    function automatic int unsigned frame_samples(input logic [CFG_W-1:0] cfg);
        int unsigned samples;
        if (cfg < 5'd12)
        begin
            // SILK sizes are not a plain power-of-two ladder.
            case (cfg[1:0])
                2'd0:    samples = 480;
                2'd1:    samples = 960;
                2'd2:    samples = 1920;
                default: samples = 2880;
            endcase
        end
        else if (cfg < 5'd16)
        begin
            samples = 480 << cfg[0];
        end
        else
        begin
            samples = 120 << cfg[1:0];
        end
        return samples;
    endfunction

    // Samples past the pre-skip scaled to nanoseconds, saturated to 63 bits.
    function automatic logic [TS_W-1:0] samples_to_ns(input logic [TOTAL_W-1:0] d);
        logic [127:0] wide;
        wide = 128'(d) * 128'(NS_PER_THREE);
        wide = wide / 128'd3;
        if (wide > 128'(TS_MAX))
        begin
            return TS_MAX;
        end
        return wide[TS_W-1:0];
    endfunction

    // Works out the result of one packet and advances the timing state.
    function automatic stamp_t stamp_packet(input logic [BYTE_W-1:0] toc,
                                            input logic [BYTE_W-1:0] cnt,
                                            input logic [LEN_W-1:0]  len);
        stamp_t             res;
        logic [COUNT_W-1:0] frames;
        logic [TS_W-1:0]    ts;
        res.dur    = '0;
        res.ts     = '0;
        res.status = ST_OK;
        if (len == '0)
        begin
            res.status = ST_EMPTY;
            empties++;
        end
        else if (toc[CODE_W-1:0] == CODE_ARBITRARY && len < MIN_LEN_COUNT)
        begin
            res.status = ST_NO_COUNT;
            missing++;
        end
        else
        begin
            case (toc[CODE_W-1:0])
                CODE_ONE:       frames = COUNT_W'(1);
                CODE_ARBITRARY: frames = cnt[COUNT_W-1:0];
                default:        frames = COUNT_W'(2);
            endcase
            res.dur    = DUR_W'(frame_samples(toc[BYTE_W-1 -: CFG_W]) * frames);
            sample_sum = sample_sum + TOTAL_W'(res.dur);
            // Nothing is presented until the total passes the pre-skip.
            if (sample_sum > TOTAL_W'(skip_len))
            begin
                ts = samples_to_ns(sample_sum - TOTAL_W'(skip_len));
            end
            else
            begin
                ts = '0;
            end
            // Timestamps never go backwards.
            if (ts < last_stamp)
            begin
                ts = last_stamp;
                clamps++;
            end
            last_stamp = ts;
            res.ts     = ts;
        end
        return res;
    endfunction

    // Reports one field that differs from its prediction.
    task automatic compare_field(input string label, input longint unsigned want_v,
                                 input longint unsigned got_v);
        if (want_v != got_v)
        begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want_v, got_v);
        end
    endtask

    // Follow both channels and the register at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        stamp_t want;
        if (!rst_n)
        begin
            sample_sum = '0;
            last_stamp = '0;
            skip_len   = '0;
            pending_stamps.delete();
            fails   = 0;
            checked = 0;
            empties = 0;
            missing = 0;
            clamps  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                skip_len = cfg_wdata;
            end
            if (packet.valid && packet.ready)
            begin
                pending_stamps.push_back(stamp_packet(packet.toc_byte, packet.count_byte,
                                                      packet.packet_length));
            end
            if (result.valid && result.ready)
            begin
                if (pending_stamps.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result, expected none, got duration %0d ts %0d",
                             $time, result.duration_samples, result.timestamp_ns);
                end
                else
                begin
                    want = pending_stamps.pop_front();
                    checked++;
                    compare_field("duration_samples", want.dur, result.duration_samples);
                    compare_field("timestamp_ns", want.ts, result.timestamp_ns);
                    compare_field("status", want.status, result.status);
                end
            end
        end
        fail_count    <= fails;
        outstanding   <= pending_stamps.size();
        checked_count <= checked;
        empty_count   <= empties;
        missing_count <= missing;
        clamp_count   <= clamps;
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the Opus packet timestamper. A directed set of packets covers
// every frame count code, the configuration ranges, empty packets, code-3
// packets without a count byte, zero and largest frame counts and totals
// below the pre-skip; random packets follow under several pre-skip values,
// with random gaps on the packet side and random stalls on the result side.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import opt_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [SKIP_W-1:0] cfg_wdata;
    logic              quiet;
    int                quiet_left;
    int                stall_left;
    int                items_sent;
    int                settings;
    int                fail_count;
    int                outstanding;
    int                checked_count;
    int                empty_count;
    int                missing_count;
    int                clamp_count;

    opt_packet_if packet_ch ();
    opt_result_if result_ch ();

    opus_packet_timestamper_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .packet    (packet_ch),
        .result    (result_ch)
    );

    opt_timestamp_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .packet        (packet_ch),
        .result        (result_ch),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count),
        .empty_count   (empty_count),
        .missing_count (missing_count),
        .clamp_count   (clamp_count)
    );

    // 8 ns clock.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Timeout well beyond the worst correct run.
    initial
    begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Gap length: mostly none, some short, a few long; none in quiet stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    // Result-side stalls, and alternating busy and quiet stretches.
    always @(posedge clk)
    begin
        if (quiet_left == 0)
        begin
            quiet      <= !quiet;
            quiet_left = $urandom_range(50, 400);
        end
        else
        begin
            quiet_left--;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    function automatic logic [BYTE_W-1:0] toc_of(input logic [CFG_W-1:0] cfg,
                                                 input logic stereo,
                                                 input logic [CODE_W-1:0] code);
        return {cfg, stereo, code};
    endfunction

    // Offers one packet after a random gap and waits until it is taken.
    task automatic send_packet(input logic [BYTE_W-1:0] toc, input logic [BYTE_W-1:0] cnt,
                               input logic [LEN_W-1:0] len);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            packet_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        packet_ch.valid         <= 1'b1;
        packet_ch.toc_byte      <= toc;
        packet_ch.count_byte    <= cnt;
        packet_ch.packet_length <= len;
        do @(posedge clk); while (!packet_ch.ready);
        items_sent++;
    endtask

    // Holds the packet side idle until every predicted result has come back.
    task automatic wait_drained();
        packet_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic set_skip_len(input logic [SKIP_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    // Random packets: mostly well-formed, with some empty and truncated ones.
    task automatic run_random(input int n);
        int               sel;
        logic [LEN_W-1:0] len;
        repeat (n)
        begin
            if ($urandom_range(99) < 3)
            begin
                wait_drained();
            end
            sel = $urandom_range(99);
            if (sel < 4)
            begin
                len = '0;
            end
            else if (sel < 9)
            begin
                len = LEN_W'(1);
            end
            else
            begin
                len = LEN_W'($urandom_range(2, 65535));
            end
            send_packet(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)), len);
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_wdata               = '0;
        quiet                   = 1'b0;
        quiet_left              = 0;
        stall_left              = 0;
        items_sent              = 0;
        settings                = 0;
        packet_ch.valid         = 1'b0;
        packet_ch.toc_byte      = '0;
        packet_ch.count_byte    = '0;
        packet_ch.packet_length = '0;
        result_ch.ready         = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Largest pre-skip: the first packets stay below it.
        set_skip_len(16'hFFFF);
        send_packet(toc_of(5'd0, 1'b0, CODE_ONE), 8'h00, 16'd1);
        send_packet(toc_of(5'd1, 1'b1, CODE_TWO_EQUAL), 8'hFF, 16'd100);
        send_packet(toc_of(5'd11, 1'b0, CODE_TWO_VAR), 8'h00, 16'hFFFF);
        send_packet(toc_of(5'd12, 1'b0, CODE_ONE), 8'h00, 16'd7);
        send_packet(toc_of(5'd15, 1'b1, CODE_TWO_EQUAL), 8'h00, 16'd9);
        send_packet(toc_of(5'd16, 1'b0, CODE_ONE), 8'h00, 16'd3);
        send_packet(toc_of(5'd31, 1'b1, CODE_ARBITRARY), 8'd5, 16'd2);
        // Empty packets, with and without a code-3 TOC.
        send_packet(8'hFF, 8'hFF, 16'd0);
        send_packet(8'h00, 8'h00, 16'd0);
        // Code 3 with no room for its count byte.
        send_packet(toc_of(5'd3, 1'b0, CODE_ARBITRARY), 8'd10, 16'd1);
        // Zero frames: the upper count bits are ignored.
        send_packet(toc_of(5'd3, 1'b0, CODE_ARBITRARY), 8'hC0, 16'd2);
        // Longest packets, which carry the total past the pre-skip.
        send_packet(toc_of(5'd3, 1'b0, CODE_ARBITRARY), 8'h3F, 16'd2);
        send_packet(toc_of(5'd3, 1'b1, CODE_ARBITRARY), 8'hFF, 16'hFFFF);
        send_packet(toc_of(5'd2, 1'b0, CODE_ONE), 8'h00, 16'h8000);
        send_packet(toc_of(5'd21, 1'b0, CODE_TWO_VAR), 8'h55, 16'h5555);
        send_packet(toc_of(5'd26, 1'b1, CODE_ONE), 8'hAA, 16'hAAAA);
        send_packet(toc_of(5'd14, 1'b0, CODE_ARBITRARY), 8'h01, 16'd3);

        // No pre-skip: timestamps jump forward.
        wait_drained();
        set_skip_len(16'h0000);
        run_random(160);

        // Largest pre-skip again: the monotonic clamp holds the timestamp.
        wait_drained();
        set_skip_len(16'hFFFF);
        run_random(160);

        wait_drained();
        set_skip_len(SKIP_W'($urandom_range(1, 65534)));
        run_random(180);

        wait_drained();
        repeat (24) @(posedge clk);
        $display("Sent %0d packets under %0d pre-skip settings: %0d empty, %0d without count byte.",
                 items_sent, settings, empty_count, missing_count);
        $display("Checked %0d results, %0d held back by the monotonic clamp, %0d mismatches.",
                 checked_count, clamp_count, fail_count);
        if (fail_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
